@@ design/bfa_pkg.sv @@
// Shared definitions for the bitmap frame allocator: field widths, codes,
// reset values and the word-level bit helpers.
// No dependencies.
`default_nettype none

package bfa_pkg;

  // Default map size in frames
  localparam int NUM_FRAMES_DEF = 65536;
  localparam int WORD_BITS      = 64;

  // Field widths
  localparam int ACTION_W   = 2;
  localparam int RANGE_W    = 17;
  localparam int FRAME_W    = 16;
  localparam int MARKED_W   = 17;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 17;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 40;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_MARK  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd2;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SCAN_START = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RESERVED   = 2'd1;

  // Register reset values
  localparam logic [FRAME_W-1:0] SCAN_START_RST = 16'h0400;
  localparam logic [RANGE_W-1:0] RESERVED_RST   = 17'h00400;

  // Bits [lo, hi) of a word, hi in 1..64
  function automatic logic [WORD_BITS-1:0] span_mask(input logic [5:0] lo,
                                                     input logic [6:0] hi);
    logic [WORD_BITS-1:0] upper;
    upper = hi[6] ? '1 : ((64'd1 << hi[5:0]) - 64'd1);
    return upper & ({WORD_BITS{1'b1}} << lo);
  endfunction

  // Adder-tree population count
  function automatic logic [6:0] popcount64(input logic [WORD_BITS-1:0] v);
    logic [1:0] s1 [32];
    logic [2:0] s2 [16];
    logic [3:0] s3 [8];
    logic [4:0] s4 [4];
    logic [5:0] s5 [2];
    for (int i = 0; i < 32; i++) s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 16; i++) s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    for (int i = 0; i < 8; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    for (int i = 0; i < 4; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    for (int i = 0; i < 2; i++)  s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    return {1'b0, s5[0]} + {1'b0, s5[1]};
  endfunction

  // Index of the set bit of a one-hot word
  function automatic logic [5:0] onehot_index(input logic [WORD_BITS-1:0] oh);
    logic [5:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (oh[i]) idx = idx | 6'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ design/bitmap_frame_allocator_unit.sv @@
// Bitmap frame allocator: sequencer around the free-map word memory.
// Depends on bfa_pkg and bfa_bitmap_ram.
//
// Use:
//   Requests enter on s_tvalid/s_tready: s_tuser carries the action (clear,
//   mark range free, allocate), s_tdata the range bounds. Every request
//   gives exactly one result on m_tvalid/m_tready: allocated frame, count
//   of newly freed frames and an out-of-memory flag.
//   Registers are written through cfg_we/cfg_addr/cfg_wdata; the user must do so only while idle,
//   as the block leaves this unchecked. Writing scan_start also reloads the allocation cursor.
// Sequence (one request at a time, the free-map RAM port sets the pace):
//   clear    : sweep over every map word, one word zeroed per cycle, then the result.
//   mark     : read the first word, then set the range bits in each word touched and count them.
//   allocate : scan from the cursor, take and clear the lowest free bit; spent cursor gives OOM.
//   other    : straight to the result.
// Reset: the map is zeroed by a sweep over every word, during which s_tready
//   stays low; registers and the cursor return to their reset values.
// Stall: the result sits in the output register until taken; the next
//   request is accepted meanwhile but its result waits for the slot.
`default_nettype none

module bitmap_frame_allocator_unit #(
  parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // s_tdata: range_start[16:0], range_end[33:17], zero fill
  input  wire logic [bfa_pkg::S_TDATA_W-1:0]    s_tdata,
  // s_tuser: action[1:0]
  input  wire logic [bfa_pkg::ACTION_W-1:0]     s_tuser,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // m_tdata: frame[15:0], pages_marked[32:16], out_of_memory[33], zero fill
  output logic      [bfa_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  input  wire logic                             cfg_we,
  input  wire logic [bfa_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [bfa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int FW = $clog2(NUM_FRAMES + 1);
  localparam int CW = (FW > bfa_pkg::RANGE_W) ? FW : bfa_pkg::RANGE_W;
  localparam int NW = (NUM_FRAMES + 63) / 64;
  localparam int AW = $clog2(NW);
  localparam int WB = bfa_pkg::WORD_BITS;

  localparam logic [CW-1:0] NF_C      = CW'(NUM_FRAMES);
  localparam logic [AW:0]   NW_C      = (AW + 1)'(NW);
  localparam logic [AW-1:0] LAST_WORD = AW'(NW - 1);

  // Sequencer states
  localparam logic [2:0] S_CLEAR      = 3'd0;
  localparam logic [2:0] S_IDLE       = 3'd1;
  localparam logic [2:0] S_MARK_CHK   = 3'd2;
  localparam logic [2:0] S_MARK       = 3'd3;
  localparam logic [2:0] S_MARK_CNT   = 3'd4;
  localparam logic [2:0] S_ALLOC_SCAN = 3'd5;
  localparam logic [2:0] S_ALLOC_PICK = 3'd6;
  localparam logic [2:0] S_FINISH     = 3'd7;

  logic [2:0]                        state;
  logic [CW-1:0]                     cursor;
  logic [bfa_pkg::FRAME_W-1:0]       scan_start;
  logic [bfa_pkg::RANGE_W-1:0]       reserved_below;
  logic [AW-1:0]                     clr_addr;
  logic                              clr_item;
  logic [CW-1:0]                     mk_start;
  logic [CW-1:0]                     mk_end;
  logic [WB-1:0]                     cnt_bits;
  logic                              cnt_pend;
  logic [AW:0]                       al_word;
  logic                              al_first;
  logic [WB-1:0]                     al_data;
  logic [WB-1:0]                     al_m;
  logic [bfa_pkg::FRAME_W-1:0]       res_frame;
  logic [bfa_pkg::MARKED_W-1:0]      res_marked;
  logic                              res_oom;

  // Memory port signals
  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  logic [WB-1:0]                     mem_wdata;
  logic                              mem_re;
  logic [AW-1:0]                     mem_raddr;
  logic [WB-1:0]                     mem_rdata;

  // Request fields
  logic [bfa_pkg::ACTION_W-1:0]      in_action;
  logic [CW-1:0]                     in_start;
  logic [CW-1:0]                     in_end;
  logic [CW-1:0]                     rb_ext;
  logic                              accept;

  // Mark datapath
  logic [CW-1:0]                     wbase;
  logic [CW-1:0]                     remain;
  logic [6:0]                        hi;
  logic [WB-1:0]                     mk_mask;
  logic [CW-1:0]                     mk_next;
  logic                              mk_more;

  // Allocation datapath
  logic [WB-1:0]                     scan_m;
  logic [AW:0]                       al_word_inc;
  logic [WB-1:0]                     pick_oh;
  logic [CW-1:0]                     pick_frame;

  assign in_action = s_tuser;
  assign in_start  = CW'(s_tdata[bfa_pkg::RANGE_W-1:0]);
  assign in_end    = CW'(s_tdata[2*bfa_pkg::RANGE_W-1:bfa_pkg::RANGE_W]);
  assign rb_ext    = CW'(reserved_below);
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;

  // Per-word span of the mark range
  assign wbase   = {mk_start[CW-1:6], 6'b0};
  assign remain  = mk_end - wbase;
  assign hi      = (remain > CW'(WB)) ? 7'd64 : remain[6:0];
  assign mk_mask = bfa_pkg::span_mask(mk_start[5:0], hi);
  assign mk_next = wbase + CW'(hi);
  assign mk_more = (mk_next < mk_end);

  // Scan candidate and lowest-bit pick
  assign scan_m      = mem_rdata & (al_first ? ({WB{1'b1}} << cursor[5:0]) : {WB{1'b1}});
  assign al_word_inc = al_word + 1'b1;
  assign pick_oh     = al_m & (~al_m + 1'b1);
  assign pick_frame  = CW'({al_word[AW-1:0], bfa_pkg::onehot_index(pick_oh)});

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      S_IDLE: begin
        mem_re    = accept && (in_action == bfa_pkg::ACT_ALLOC);
        mem_raddr = cursor[AW+5:6];
      end
      S_MARK_CHK: begin
        mem_re    = 1'b1;
        mem_raddr = mk_start[AW+5:6];
      end
      S_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = mk_start[AW+5:6];
        mem_wdata = mem_rdata | mk_mask;
        mem_re    = mk_more;
        mem_raddr = mk_start[AW+5:6] + 1'b1;
      end
      S_ALLOC_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = al_word_inc[AW-1:0];
      end
      S_ALLOC_PICK: begin
        mem_we    = (pick_frame < NF_C);
        mem_waddr = al_word[AW-1:0];
        mem_wdata = al_data & ~pick_oh;
      end
      default: begin
      end
    endcase
  end

  bfa_bitmap_ram #(
    .DEPTH (NW),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      clr_item       <= 1'b0;
      cnt_pend       <= 1'b0;
      cursor         <= CW'(bfa_pkg::SCAN_START_RST);
      scan_start     <= bfa_pkg::SCAN_START_RST;
      reserved_below <= bfa_pkg::RESERVED_RST;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_WORD) begin
            clr_addr <= '0;
            state    <= clr_item ? S_FINISH : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (in_action)
              bfa_pkg::ACT_CLEAR: begin
                clr_item <= 1'b1;
                state    <= S_CLEAR;
              end
              bfa_pkg::ACT_MARK: begin
                state <= S_MARK_CHK;
              end
              bfa_pkg::ACT_ALLOC: begin
                if (cursor >= NF_C) begin
                  cursor <= NF_C;
                  state  <= S_FINISH;
                end else begin
                  state <= S_ALLOC_SCAN;
                end
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_MARK_CHK: begin
          state <= (mk_start < mk_end) ? S_MARK : S_FINISH;
        end
        S_MARK: begin
          cnt_pend <= 1'b1;
          if (!mk_more) state <= S_MARK_CNT;
        end
        S_MARK_CNT: begin
          cnt_pend <= 1'b0;
          state    <= S_FINISH;
        end
        S_ALLOC_SCAN: begin
          if (scan_m != '0) begin
            state <= S_ALLOC_PICK;
          end else if (al_word_inc >= NW_C) begin
            cursor <= NF_C;
            state  <= S_FINISH;
          end
        end
        S_ALLOC_PICK: begin
          cursor <= (pick_frame < NF_C) ? pick_frame : NF_C;
          state  <= S_FINISH;
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            clr_item <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // Register writes; the user must issue them only while idle, the block does not enforce this
      if (cfg_we) begin
        if (cfg_addr == bfa_pkg::REG_SCAN_START) begin
          scan_start <= cfg_wdata[bfa_pkg::FRAME_W-1:0];
          cursor     <= CW'(cfg_wdata[bfa_pkg::FRAME_W-1:0]);
        end else if (cfg_addr == bfa_pkg::REG_RESERVED) begin
          reserved_below <= cfg_wdata;
        end
      end
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    if (cnt_pend) begin
      res_marked <= res_marked + bfa_pkg::MARKED_W'(bfa_pkg::popcount64(cnt_bits));
    end
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_frame  <= '0;
          res_marked <= '0;
          res_oom    <= 1'b0;
          mk_start   <= (in_start < rb_ext) ? rb_ext : in_start;
          mk_end     <= (in_end > NF_C) ? NF_C : in_end;
          al_word    <= {1'b0, cursor[AW+5:6]};
          al_first   <= 1'b1;
          if (in_action == bfa_pkg::ACT_ALLOC && cursor >= NF_C) res_oom <= 1'b1;
        end
      end
      S_MARK: begin
        cnt_bits <= mk_mask & ~mem_rdata;
        mk_start <= mk_next;
      end
      S_ALLOC_SCAN: begin
        al_data <= mem_rdata;
        al_m    <= scan_m;
        if (scan_m == '0) begin
          al_word  <= al_word_inc;
          al_first <= 1'b0;
          if (al_word_inc >= NW_C) res_oom <= 1'b1;
        end
      end
      S_ALLOC_PICK: begin
        if (pick_frame < NF_C) begin
          res_frame <= pick_frame[bfa_pkg::FRAME_W-1:0];
        end else begin
          res_oom <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_FINISH && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!m_tvalid || m_tready)) begin
      m_tdata <= {6'b0, res_oom, res_marked, res_frame};
    end
  end

endmodule

`default_nettype wire

@@ design/bfa_bitmap_ram.sv @@
// Free-map storage: one write port and one read port, registered read data.
// Depends on bfa_pkg for the word width.
`default_nettype none

module bfa_bitmap_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [AW-1:0]                 waddr,
  input  wire logic [bfa_pkg::WORD_BITS-1:0] wdata,
  input  wire logic                          re,
  input  wire logic [AW-1:0]                 raddr,
  output logic      [bfa_pkg::WORD_BITS-1:0] rdata
);

  logic [bfa_pkg::WORD_BITS-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/bfa_checker.sv @@
// Port-level checks for the bitmap frame allocator, bound to the top level.
// Depends on bfa_pkg for port widths.
`default_nettype none

module bfa_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic [bfa_pkg::M_TDATA_W-1:0] m_tdata,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready
);

  // Reset starts the map sweep, so no request is taken right after it
  a_reset_busy: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("request port ready right after reset");

  // One request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request port ready again right after an accept");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // Failed allocation reports no frame and no count
  a_oom_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[33]) |-> (m_tdata[15:0] == 16'd0 && m_tdata[32:16] == 17'd0))
    else $error("out-of-memory result carries data");

  // A mark count never comes with a frame
  a_mark_no_frame: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[32:16] != 17'd0) |-> (m_tdata[15:0] == 16'd0))
    else $error("mark result carries a frame");

endmodule

bind bitmap_frame_allocator_unit bfa_checker u_bfa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

`default_nettype wire
